/* design/quantized_glissando_macros.svh */
// ----------------------------------------------------------------------------
// Quantized glissando assertion macros
// Shorthand for the clocked, reset-qualified checks used in the design.
// ----------------------------------------------------------------------------
`ifndef QUANTIZED_GLISSANDO_MACROS_SVH
`define QUANTIZED_GLISSANDO_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QG_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/qg_pkg.sv */
// ----------------------------------------------------------------------------
// Quantized glissando package
// Field widths, register indexes, command and status types.
// ----------------------------------------------------------------------------
package qg_pkg;

    localparam int MAX_TABLE_DEF = 32;

    localparam int FRAC_W     = 16;
    localparam int SAMPLE_W   = 16;
    localparam int SIZE_W     = 6;
    localparam int GLIDE_W    = 17;
    localparam int WIDX_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GLIDE_FRACTION = 2'd1;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    localparam logic [SIZE_W-1:0]  SIZE_RESET  = 6'd1;
    localparam logic [GLIDE_W-1:0] GLIDE_RESET = 17'd32768;
    localparam logic [FRAC_W-1:0]  START_RESET = 16'h8000;

    localparam int DIV_STEPS = 16;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        MUL_TT  = 2'd0,
        MUL_WT  = 2'd1,
        MUL_MIX = 2'd2
    } mul_sel_t;

    typedef struct packed {
        logic     table_wr;
        logic     capture_tick;
        logic     fetch;
        logic     update;
        logic     compare;
        logic     div_step;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     load_out;
    } qg_cmd_t;

    typedef struct packed {
        logic is_write;
        logic first_pending;
        logic below_start;
        logic div_last;
        logic out_blocked;
    } qg_status_t;

endpackage

/* design/qg_item_if.sv */
// ----------------------------------------------------------------------------
// Quantized glissando input channel
// Valid/ready channel carrying one tick or one table write per beat.
// ----------------------------------------------------------------------------
interface qg_item_if;
    logic                              valid;
    logic                              ready;
    logic                              func;
    logic [qg_pkg::FRAC_W-1:0]         value_in;
    logic [qg_pkg::FRAC_W-1:0]         phase;
    logic [qg_pkg::WIDX_W-1:0]         table_index;
    logic signed [qg_pkg::SAMPLE_W-1:0] table_word;

    modport source (
        output valid, func, value_in, phase, table_index, table_word,
        input  ready
    );

    modport sink (
        input  valid, func, value_in, phase, table_index, table_word,
        output ready
    );
endinterface

/* design/qg_result_if.sv */
// ----------------------------------------------------------------------------
// Quantized glissando result channel
// Valid/ready channel carrying one output sample per beat.
// ----------------------------------------------------------------------------
interface qg_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [qg_pkg::SAMPLE_W-1:0] out_value;

    modport source (
        output valid, out_value,
        input  ready
    );

    modport sink (
        input  valid, out_value,
        output ready
    );
endinterface

/* design/qg_cfg_if.sv */
// ----------------------------------------------------------------------------
// Quantized glissando configuration channel
// Valid/ready register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface qg_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [qg_pkg::CFG_IDX_W-1:0]  index;
    logic [qg_pkg::CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

/* design/qg_ctrl.sv */
// ----------------------------------------------------------------------------
// Quantized glissando controller
// Sequences table fetch, target update, divide, cubing and the final blend.
// ----------------------------------------------------------------------------
`include "quantized_glissando_macros.svh"

module qg_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  qg_pkg::qg_status_t status,
    output qg_pkg::qg_cmd_t    cmd
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_READ   = 9'b000000010,
        S_UPDATE = 9'b000000100,
        S_CMP    = 9'b000001000,
        S_DIV    = 9'b000010000,
        S_SQ     = 9'b000100000,
        S_CUBE   = 9'b001000000,
        S_MIX    = 9'b010000000,
        S_FINAL  = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    if (status.is_write)
                    begin
                        cmd.table_wr = 1'b1;
                    end
                    else
                    begin
                        cmd.capture_tick = 1'b1;
                        state_next       = S_READ;
                    end
                end
            end
            S_READ:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                // The first tick only loads both targets; its weight is zero.
                cmd.update = 1'b1;
                state_next = status.first_pending ? S_MIX : S_CMP;
            end
            S_CMP:
            begin
                cmd.compare = 1'b1;
                state_next  = status.below_start ? S_MIX : S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = qg_pkg::MUL_TT;
                state_next  = S_CUBE;
            end
            S_CUBE:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = qg_pkg::MUL_WT;
                state_next  = S_MIX;
            end
            S_MIX:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = qg_pkg::MUL_MIX;
                state_next  = S_FINAL;
            end
            S_FINAL:
            begin
                if (!status.out_blocked)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `QG_ASSERT_NEXT(a_tick_starts_fetch, clk, rst_n, item_valid && item_ready && !status.is_write, state_reg == S_READ, "accepted tick did not start a fetch")
    `QG_ASSERT_NEXT(a_write_stays_idle, clk, rst_n, item_valid && item_ready && status.is_write, state_reg == S_IDLE, "table write left the idle state")
    `QG_ASSERT_NEXT(a_div_exits_to_square, clk, rst_n, state_reg == S_DIV && status.div_last, state_reg == S_SQ, "divider end did not lead to squaring")

endmodule

/* design/qg_dp.sv */
// ----------------------------------------------------------------------------
// Quantized glissando datapath
// Table memory, target registers, restoring divider, shared multiplier and
// the output register.
// ----------------------------------------------------------------------------
`include "quantized_glissando_macros.svh"

module qg_dp #(
    parameter int MAX_TABLE = qg_pkg::MAX_TABLE_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_func,
    input  logic [qg_pkg::FRAC_W-1:0]          item_value_in,
    input  logic [qg_pkg::FRAC_W-1:0]          item_phase,
    input  logic [qg_pkg::WIDX_W-1:0]          item_table_index,
    input  logic signed [qg_pkg::SAMPLE_W-1:0] item_table_word,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [qg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [qg_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic signed [qg_pkg::SAMPLE_W-1:0] result_value,
    input  qg_pkg::qg_cmd_t                    cmd,
    output qg_pkg::qg_status_t                 status
);

    localparam int IDX_W    = $clog2(MAX_TABLE);
    localparam int SIZE_MAX = (1 << qg_pkg::SIZE_W) - 1;
    localparam int SIZE_CAP = (MAX_TABLE < SIZE_MAX) ? MAX_TABLE : SIZE_MAX;
    localparam int PROD_W   = qg_pkg::FRAC_W + qg_pkg::SIZE_W;

    logic signed [qg_pkg::SAMPLE_W-1:0] mem [MAX_TABLE];

    logic [qg_pkg::SIZE_W-1:0]          size_reg;
    logic [qg_pkg::GLIDE_W-1:0]         glide_reg;
    logic                               first_reg;
    logic [qg_pkg::FRAC_W-1:0]          start_reg;
    logic [qg_pkg::FRAC_W-1:0]          last_phase_reg;
    logic signed [qg_pkg::SAMPLE_W-1:0] prev_reg;
    logic signed [qg_pkg::SAMPLE_W-1:0] next_reg;
    logic                               out_valid_reg;

    logic [qg_pkg::FRAC_W-1:0]          frac_reg;
    logic [qg_pkg::FRAC_W-1:0]          phase_reg;
    logic signed [qg_pkg::SAMPLE_W-1:0] rd_reg;
    logic [qg_pkg::FRAC_W-1:0]          rem_reg;
    logic [qg_pkg::FRAC_W-1:0]          quo_reg;
    logic [qg_pkg::CNT_W-1:0]           cnt_reg;
    logic signed [35:0]                 prod_reg;
    logic signed [qg_pkg::SAMPLE_W-1:0] out_value_reg;

    logic [qg_pkg::SIZE_W-1:0] size_eff;
    logic [PROD_W-1:0]         idx_prod;
    logic [IDX_W-1:0]          rd_addr;
    logic                      wr_in_range;
    logic                      glide_ok;
    logic                      wrap;
    logic                      below_start;
    logic [qg_pkg::FRAC_W:0]   divisor;
    logic [qg_pkg::FRAC_W:0]   rem_ext;
    logic [qg_pkg::FRAC_W:0]   rem_shift;
    logic [qg_pkg::FRAC_W:0]   rem_sub;
    logic                      rem_ge;
    logic signed [16:0]        diff;
    logic signed [17:0]        mul_a;
    logic signed [17:0]        mul_b;
    logic signed [35:0]        mix_sum;

    // Effective size: zero acts as one, anything past the table as its depth.
    always_comb
    begin
        priority if (size_reg == '0)
        begin
            size_eff = qg_pkg::SIZE_W'(1);
        end
        else if (size_reg > qg_pkg::SIZE_W'(SIZE_CAP))
        begin
            size_eff = qg_pkg::SIZE_W'(SIZE_CAP);
        end
        else
        begin
            size_eff = size_reg;
        end
    end

    // The scaled index is always below the size, so no clamp is needed.
    assign idx_prod    = PROD_W'(frac_reg) * PROD_W'(size_eff);
    assign rd_addr     = IDX_W'(idx_prod[PROD_W-1:qg_pkg::FRAC_W]);
    assign wr_in_range = 32'(item_table_index) < MAX_TABLE;

    assign glide_ok    = !glide_reg[qg_pkg::FRAC_W] && (glide_reg[qg_pkg::FRAC_W-1:0] != '0);
    assign wrap        = phase_reg < last_phase_reg;
    assign below_start = phase_reg < start_reg;

    assign divisor   = 17'h10000 - {1'b0, start_reg};
    assign rem_ext   = {1'b0, rem_reg};
    assign rem_shift = {rem_reg, 1'b0};
    assign rem_ge    = rem_shift >= divisor;
    assign rem_sub   = rem_shift - divisor;

    assign diff = $signed({next_reg[15], next_reg}) - $signed({prev_reg[15], prev_reg});

    always_comb
    begin
        unique case (cmd.mul_sel)
            qg_pkg::MUL_TT:
            begin
                mul_a = $signed({2'b00, quo_reg});
                mul_b = $signed({2'b00, quo_reg});
            end
            qg_pkg::MUL_WT:
            begin
                mul_a = $signed({2'b00, prod_reg[31:16]});
                mul_b = $signed({2'b00, quo_reg});
            end
            qg_pkg::MUL_MIX:
            begin
                mul_a = $signed({2'b00, prod_reg[31:16]});
                mul_b = {diff[16], diff};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // prev * 2^16 + w * (next - prev), rounded half up.
    assign mix_sum = $signed({{4{prev_reg[15]}}, prev_reg, 16'h0000}) + prod_reg
                     + 36'sd32768;

    always_ff @(posedge clk)
    begin
        if (cmd.table_wr && wr_in_range)
        begin
            mem[IDX_W'(item_table_index)] <= item_table_word;
        end
        if (cmd.fetch)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg       <= qg_pkg::SIZE_RESET;
            glide_reg      <= qg_pkg::GLIDE_RESET;
            first_reg      <= 1'b1;
            start_reg      <= qg_pkg::START_RESET;
            last_phase_reg <= '0;
            prev_reg       <= '0;
            next_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    qg_pkg::CFG_TABLE_SIZE:
                    begin
                        size_reg <= cfg_data[qg_pkg::SIZE_W-1:0];
                    end
                    qg_pkg::CFG_GLIDE_FRACTION:
                    begin
                        glide_reg <= cfg_data;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.update)
            begin
                last_phase_reg <= phase_reg;
                if (first_reg)
                begin
                    first_reg <= 1'b0;
                    prev_reg  <= rd_reg;
                    next_reg  <= rd_reg;
                end
                else if (wrap)
                begin
                    prev_reg <= next_reg;
                    next_reg <= rd_reg;
                end
                if ((first_reg || wrap) && glide_ok)
                begin
                    start_reg <= glide_reg[qg_pkg::FRAC_W-1:0];
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture_tick)
        begin
            frac_reg  <= item_value_in;
            phase_reg <= item_phase;
        end
        if (cmd.update && first_reg)
        begin
            prod_reg <= '0;
        end
        if (cmd.compare)
        begin
            if (below_start)
            begin
                prod_reg <= '0;
            end
            rem_reg <= phase_reg - start_reg;
            quo_reg <= '0;
            cnt_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? rem_sub[qg_pkg::FRAC_W-1:0] : rem_shift[qg_pkg::FRAC_W-1:0];
            quo_reg <= {quo_reg[qg_pkg::FRAC_W-2:0], rem_ge};
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= 36'(mul_a) * 36'(mul_b);
        end
        if (cmd.load_out)
        begin
            out_value_reg <= mix_sum[31:16];
        end
    end

    assign cfg_ready    = 1'b1;
    assign result_valid = out_valid_reg;
    assign result_value = out_value_reg;

    assign status.is_write      = item_func == qg_pkg::FUNC_WRITE;
    assign status.first_pending = first_reg;
    assign status.below_start   = below_start;
    assign status.div_last      = cnt_reg == qg_pkg::CNT_W'(qg_pkg::DIV_STEPS - 1);
    assign status.out_blocked   = out_valid_reg && !result_ready;

    `QG_ASSERT_IMPLY(a_start_nonzero, clk, rst_n, 1'b1, start_reg != '0, "glide start latched as zero")
    `QG_ASSERT_IMPLY(a_rem_below_divisor, clk, rst_n, cmd.div_step, rem_ext < divisor, "divider remainder reached the divisor")

endmodule

/* design/quantized_glissando.sv */
// ----------------------------------------------------------------------------
// Quantized glissando
// Table-driven stepped value that glides to its next step along t^3.
// ----------------------------------------------------------------------------
// Usage:
// The item channel carries one beat per tick or per table write. A write beat
// (func high) stores table_word at table_index and gives no result; it is
// taken in the idle state, which the block keeps. A tick beat gives exactly
// one beat on the result channel. The cfg channel writes table_size (index 0)
// and glide_fraction (index 1); it is always ready. The user must write it only
// while the block is idle, which the block itself does not enforce. The first
// tick after reset only loads the targets; a tick whose phase is below the
// glide start skips the divide; a gliding tick runs the 16-step restoring
// divider for (phase - start) / (1 - start). A new beat is taken in the cycle
// the result appears. Reset clears the targets, the last phase and the result
// valid flag and arms the first-tick load; table contents stay undefined until
// written. If the receiver stalls, the finished result waits in the output
// register; the next tick is still accepted and runs until its own result
// would overwrite it, then holds there until the pending beat is taken.
// ----------------------------------------------------------------------------
module quantized_glissando #(
    parameter int MAX_TABLE = qg_pkg::MAX_TABLE_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    qg_item_if.sink            item,
    qg_result_if.source        result,
    qg_cfg_if.sink             cfg
);

    // Commands from the controller and status back from the datapath.
    qg_pkg::qg_cmd_t    cmd;
    qg_pkg::qg_status_t status;

    qg_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .status     (status),
        .cmd        (cmd)
    );

    qg_dp #(
        .MAX_TABLE (MAX_TABLE)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_func        (item.func),
        .item_value_in    (item.value_in),
        .item_phase       (item.phase),
        .item_table_index (item.table_index),
        .item_table_word  (item.table_word),
        .cfg_valid        (cfg.valid),
        .cfg_ready        (cfg.ready),
        .cfg_index        (cfg.index),
        .cfg_data         (cfg.data),
        .result_valid     (result.valid),
        .result_ready     (result.ready),
        .result_value     (result.out_value),
        .cmd              (cmd),
        .status           (status)
    );

endmodule
